// File: rtl/mexp_pkg.sv
// mexp_pkg: shared widths, types and the modular add used by the exponentiation unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    localparam int OPERAND_WIDTH = 24;
    localparam int CNT_W = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [CNT_W-1:0] bit_cnt_t;

    // request to the modular multiplier: go pulses for one cycle with the operands
    typedef struct packed {
        logic     go;
        operand_t a;
        operand_t b;
        operand_t m;
    } mul_req_t;

    // (x + y) mod m for x, y < m, one add and one compare-subtract
    function automatic operand_t add_mod(input operand_t x, input operand_t y,
                                         input operand_t m);
        logic [OPERAND_WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[OPERAND_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/mexp_mulmod.sv
// mexp_mulmod: bit-serial modular multiplier, one multiplier bit per cycle, msb first
// depends on mexp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mexp_pkg::mul_req_t req,
    output logic                   done,
    output mexp_pkg::operand_t     product
);
    import mexp_pkg::*;

    operand_t a_reg;
    operand_t b_reg, b_next;
    operand_t m_reg;
    operand_t acc_reg, acc_next;
    bit_cnt_t cnt_reg, cnt_next;
    logic     run_reg, run_next;
    logic     done_reg, done_next;
    operand_t dbl;

    // double, then add a when the top multiplier bit is set
    always_comb
    begin
        dbl      = add_mod(acc_reg, acc_reg, m_reg);
        acc_next = acc_reg;
        b_next   = b_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            acc_next = '0;
            b_next   = req.b;
            cnt_next = bit_cnt_t'(OPERAND_WIDTH - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = b_reg[OPERAND_WIDTH-1] ? add_mod(dbl, a_reg, m_reg) : dbl;
            b_next   = {b_reg[OPERAND_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            a_reg <= req.a;
            m_reg <= req.m;
        end
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// File: rtl/modular_exponentiation_unit.sv
// modular_exponentiation_unit: square-and-multiply controller around a bit-serial multiplier
// depends on mexp_pkg and mexp_mulmod
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake           | payload
// ----------+---------------------+-------------------------------
// request   | start, busy         | base, exponent, modulus
// result    | done (one cycle)    | result, modulus_zero
//
// a request is taken when start is high and busy is low; the unit then works alone
// each modular product goes through the shared bit-serial multiplier
// one reduction, then per exponent bit an optional multiply and a square
// until no set bits remain
// a zero modulus answers in the cycle after the request with modulus_zero set and result 0
// reset clears the controller and multiplier; the receiver cannot stall results

module modular_exponentiation_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire mexp_pkg::operand_t base,
    input  wire mexp_pkg::operand_t exponent,
    input  wire mexp_pkg::operand_t modulus,
    output logic                    done,
    output mexp_pkg::operand_t      result,
    output logic                    modulus_zero
);
    import mexp_pkg::*;

    // controller states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_SQR    = 3'd4;

    logic [2:0] state_reg, state_next;
    operand_t   e_reg, e_next;          // exponent, consumed lsb first
    operand_t   m_reg, m_next;
    operand_t   power_reg, power_next;  // current square of the base
    operand_t   acc_reg, acc_next;      // running result
    mul_req_t   req_reg, req_next;
    logic       done_reg, done_next;
    operand_t   result_reg, result_next;
    logic       mz_reg, mz_next;

    logic       mul_done;
    operand_t   mul_product;

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb
    begin
        state_next  = state_reg;
        e_next      = e_reg;
        m_next      = m_reg;
        power_next  = power_reg;
        acc_next    = acc_reg;
        req_next    = req_reg;
        req_next.go = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        mz_next     = mz_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (modulus == '0)
                    begin
                        // error answer straight away
                        done_next   = 1'b1;
                        result_next = '0;
                        mz_next     = 1'b1;
                    end
                    else
                    begin
                        // base mod m as 1 * base mod m through the multiplier
                        e_next     = exponent;
                        m_next     = modulus;
                        req_next.go = 1'b1;
                        req_next.a = operand_t'(1);
                        req_next.b = base;
                        req_next.m = modulus;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mul_done)
                begin
                    power_next = mul_product;
                    // 1 mod m
                    acc_next   = (m_reg == operand_t'(1)) ? '0 : operand_t'(1);
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                req_next.m = m_reg;
                if (e_reg == '0)
                begin
                    // no set bits left, further squares cannot change the answer
                    done_next   = 1'b1;
                    result_next = acc_reg;
                    mz_next     = 1'b0;
                    state_next  = S_IDLE;
                end
                else if (e_reg[0])
                begin
                    req_next.go = 1'b1;
                    req_next.a  = acc_reg;
                    req_next.b  = power_reg;
                    state_next  = S_MUL;
                end
                else
                begin
                    req_next.go = 1'b1;
                    req_next.a  = power_reg;
                    req_next.b  = power_reg;
                    state_next  = S_SQR;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    acc_next    = mul_product;
                    req_next.go = 1'b1;
                    req_next.a  = power_reg;
                    req_next.b  = power_reg;
                    req_next.m  = m_reg;
                    state_next  = S_SQR;
                end
            end
            S_SQR:
            begin
                if (mul_done)
                begin
                    power_next = mul_product;
                    e_next     = {1'b0, e_reg[OPERAND_WIDTH-1:1]};
                    state_next = S_DECIDE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        m_reg      <= m_next;
        power_reg  <= power_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        mz_reg     <= mz_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result       = result_reg;
    assign modulus_zero = mz_reg;

`ifndef SYNTHESIS
    // a result is only presented once the controller is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while controller busy");

    // a normal result is always reduced below the modulus
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !modulus_zero) |-> (result < m_reg))
        else $error("result not reduced modulo modulus");

    // the multiplier only finishes while the controller waits on it
    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_REDUCE || state_reg == S_MUL || state_reg == S_SQR))
        else $error("multiplier finished with no product pending");

    // the error answer carries a zero result
    a_zero_mod_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && modulus_zero) |-> (result == '0))
        else $error("zero modulus with non-zero result");
`endif

endmodule

`default_nettype wire
